// File: rtl/core/rbpfc_pkg.sv
// ----------------------------------------------------------------------------
// rbpfc_pkg
// Shared types and constants for the repeating bit pattern fill/check block.
// ----------------------------------------------------------------------------
package rbpfc_pkg;

  localparam int PATTERN_MAX = 64;
  localparam int POS_W       = $clog2(PATTERN_MAX);
  localparam int LEN_W       = POS_W + 1;
  localparam int BYTE_W      = 8;
  localparam int BITCNT_W    = $clog2(BYTE_W);
  localparam int OFFSET_W    = 32;
  localparam int OUT_W       = 48;

  // Command codes carried in s_tuser
  localparam logic CMD_FILL  = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  // Register indexes on the config port
  localparam logic REG_PATTERN_BITS = 1'b0;
  localparam logic REG_PATTERN_LEN  = 1'b1;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(BYTE_W);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // Control from the sequencer to the serial datapath
  typedef struct packed {
    logic load;     // item accepted: capture data byte, clear accumulators
    logic step;     // one pattern bit this cycle
    logic restart;  // range ended: position back to the first pattern bit
  } ctl_t;

endpackage

// File: rtl/core/rbpfc_bitgen.sv
// ----------------------------------------------------------------------------
// rbpfc_bitgen
// Pattern position counter; emits one pattern bit per step.
// ----------------------------------------------------------------------------
module rbpfc_bitgen
  import rbpfc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  ctl_t                   ctl,
  input  logic [PATTERN_MAX-1:0] pattern_bits,
  input  logic [LEN_W-1:0]       pattern_len,
  output logic                   pat_bit
);

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic [LEN_W-1:0] eff_len;
  logic [LEN_W-1:0] pos_inc;

  // zero length acts as one, oversize clamps to the max
  always_comb begin
    if (pattern_len == '0) begin
      eff_len = LEN_W'(1);
    end else if (pattern_len > LEN_W'(PATTERN_MAX)) begin
      eff_len = LEN_W'(PATTERN_MAX);
    end else begin
      eff_len = pattern_len;
    end
  end

  assign pat_bit  = pattern_bits[pos];
  assign pos_inc  = {1'b0, pos} + LEN_W'(1);
  assign pos_next = (pos_inc >= eff_len) ? '0 : pos_inc[POS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (ctl.restart) begin
      pos <= '0;
    end else if (ctl.step) begin
      pos <= pos_next;
    end
  end

endmodule

// File: rtl/core/rbpfc_shift.sv
// ----------------------------------------------------------------------------
// rbpfc_shift
// Builds the expected byte MSB first and compares the data byte bit by bit.
// ----------------------------------------------------------------------------
module rbpfc_shift
  import rbpfc_pkg::*;
(
  input  logic              clk,
  input  ctl_t              ctl,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              pat_bit,
  output logic [BYTE_W-1:0] exp_byte,
  output logic              mis_any
);

  logic [BYTE_W-1:0] data_sh;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data_sh  <= data_byte;
      exp_byte <= '0;
      mis_any  <= 1'b0;
    end else if (ctl.step) begin
      exp_byte <= {exp_byte[BYTE_W-2:0], pat_bit};
      data_sh  <= {data_sh[BYTE_W-2:0], 1'b0};
      mis_any  <= mis_any | (data_sh[BYTE_W-1] ^ pat_bit);
    end
  end

endmodule

// File: rtl/core/repeating_bit_pattern_fill_check.sv
// ----------------------------------------------------------------------------
// repeating_bit_pattern_fill_check
// Fill/check engine for a byte stream built from a repeating bit pattern.
// ----------------------------------------------------------------------------
// Flow: an accepted item steps one pattern bit per clock in ST_RUN, eight per
//   byte, then ST_DONE loads the output register when it is free.
//   The bit stepper sets the item rate while the output is free.
// The next item is taken while a result still waits in the output register.
// Reset (rst, synchronous): position, offset, failed flag and output valid clear;
//   pattern_bits resets to zero and pattern_len to 8.
module repeating_bit_pattern_fill_check
  import rbpfc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // config write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [PATTERN_MAX-1:0] cfg_data,
  // input items
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [BYTE_W-1:0]      s_tdata,   // [7:0] data_byte
  input  logic                   s_tuser,   // [0] cmd
  input  logic                   s_tlast,   // last_of_range
  // result items
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_W-1:0]       m_tdata,   // [7:0] pattern_byte, [8] mismatch,
                                            // [9] first_mismatch,
                                            // [41:10] byte_offset, [47:42] zero
  output logic                   m_tlast    // range_done
);

  // Configuration registers
  logic [PATTERN_MAX-1:0] pattern_bits;
  logic [LEN_W-1:0]       pattern_len;

  // Sequencer
  state_t              state, state_next;
  logic [BITCNT_W-1:0] cnt;
  ctl_t                ctl;
  logic                out_load;

  // Per-item captured fields
  logic cmd_q;
  logic last_q;

  // Range state
  logic [OFFSET_W-1:0] byte_counter;
  logic                already_failed;

  // Datapath
  logic              pat_bit;
  logic [BYTE_W-1:0] exp_byte;
  logic              mis_any;
  logic              mis;
  logic              first;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bits <= '0;
      pattern_len  <= LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PATTERN_BITS: pattern_bits <= cfg_data;
        REG_PATTERN_LEN:  pattern_len  <= cfg_data[LEN_W-1:0];
        default:          ;
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state == ST_RUN) ? cnt + BITCNT_W'(1) : '0;
    end
  end

  always_comb begin
    state_next  = state;
    ctl.load    = 1'b0;
    ctl.step    = 1'b0;
    ctl.restart = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          ctl.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        ctl.step = 1'b1;
        if (cnt == BITCNT_W'(BYTE_W - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          ctl.restart = last_q;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q  <= s_tuser;
      last_q <= s_tlast;
    end
  end

  rbpfc_bitgen u_bitgen (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .pattern_bits (pattern_bits),
    .pattern_len  (pattern_len),
    .pat_bit      (pat_bit)
  );

  rbpfc_shift u_shift (
    .clk       (clk),
    .ctl       (ctl),
    .data_byte (s_tdata),
    .pat_bit   (pat_bit),
    .exp_byte  (exp_byte),
    .mis_any   (mis_any)
  );

  // Fill mode never flags a mismatch
  assign mis   = (cmd_q == CMD_CHECK) && mis_any;
  assign first = mis && !already_failed;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_counter   <= '0;
      already_failed <= 1'b0;
    end else if (out_load) begin
      if (last_q) begin
        byte_counter   <= '0;
        already_failed <= 1'b0;
      end else begin
        byte_counter   <= byte_counter + OFFSET_W'(1);
        already_failed <= already_failed | mis;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {(OUT_W - OFFSET_W - BYTE_W - 2)'(0), byte_counter, first, mis, exp_byte};
      m_tlast <= last_q;
    end
  end

`ifndef SYNTHESIS
  a_first_implies_mis: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[9] || m_tdata[8]))
    else $error("first_mismatch without mismatch");

  a_accept_starts_run: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_RUN && cnt == '0))
    else $error("accepted item did not start the bit run");

  a_range_restart: assert property (@(posedge clk) disable iff (rst)
    (out_load && last_q) |=> (byte_counter == '0 && !already_failed))
    else $error("range state not cleared after last item");

  a_run_length: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && cnt == BITCNT_W'(BYTE_W - 1)) |=> (state == ST_DONE))
    else $error("bit run did not end after one byte");
`endif

endmodule

// File: test/repeating_bit_pattern_fill_check_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// repeating_bit_pattern_fill_check_tb
// Self-checking bench for the pattern fill/check engine. A short directed table
// covers reset values, all-zero and all-one patterns, length clamping, later
// mismatches and a length shrink in mid range. Random phases follow with new
// register settings. Every item is scored against an in-bench pattern walker or
// a typed-in result, with random stalls on both streams.
// ----------------------------------------------------------------------------
module repeating_bit_pattern_fill_check_tb;
  import rbpfc_pkg::*;

  localparam int RAND_ITEMS = 430;   // random items after the directed table
  localparam int IDLE_LIMIT = 1000;  // cycles without any handshake before giving up
  localparam int DRAIN_WAIT = 16;    // block latency plus margin

  // one result item as the bench expects it
  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic                first;
    logic                mis;
    logic [BYTE_W-1:0]   pbyte;
    logic                done;
  } result_t;

  // pattern byte and the position that follows it
  typedef struct packed {
    logic [POS_W-1:0]  next_pos;
    logic [BYTE_W-1:0] pbyte;
  } walk_t;

  // directed table row: either a register write or an input item
  typedef struct packed {
    logic                   is_cfg;
    logic                   cfg_idx;
    logic [PATTERN_MAX-1:0] cfg_val;
    logic                   cmd;
    logic [BYTE_W-1:0]      data;
    logic                   last;
    logic                   known;   // typed-in result below is used as is
    result_t                res;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_index = REG_PATTERN_BITS;
  logic [PATTERN_MAX-1:0] cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [BYTE_W-1:0]      s_tdata = '0;   // [7:0] data_byte
  logic                   s_tuser = CMD_FILL;   // [0] cmd
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b1;
  logic [OUT_W-1:0]       m_tdata;  // [7:0] pattern_byte, [8] mismatch, [9] first_mismatch,
                                    // [41:10] byte_offset, [47:42] zero
  logic                   m_tlast;  // range_done

  repeating_bit_pattern_fill_check DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench copy of the block state (registers at reset values)
  // --------------------------------------------------------------------------
  logic [PATTERN_MAX-1:0] pat_bits = '0;
  logic [LEN_W-1:0]       pat_len = LEN_RESET;
  logic [POS_W-1:0]       bit_pos = '0;
  logic [OFFSET_W-1:0]    offset_cnt = '0;
  logic                   range_failed = 1'b0;

  result_t    pending_results[$];  // results owed by the block, oldest first
  plan_row_t  plan[$];
  logic       row_known = 1'b0;    // driven item carries a typed-in result
  result_t    row_res;
  logic       calm = 1'b0;         // no stalls on either stream
  int         stall_left = 0;
  int         range_left = 0;
  int         errors = 0;
  int         idle_cycles = 0;
  int         n_items = 0, n_checks = 0, n_mis = 0, n_first = 0, n_ranges = 0, n_cfg = 0;
  int         n_random = 0;

  // Walk eight pattern bits from a position, MSB of the byte first. A length
  // of zero acts as one, lengths past PATTERN_MAX act as PATTERN_MAX. A stale
  // position at or past the length still selects its bit, then wraps to zero.
  function automatic walk_t walk_pattern(input logic [PATTERN_MAX-1:0] bits,
                                         input logic [LEN_W-1:0] len,
                                         input logic [POS_W-1:0] start);
    walk_t w;
    int    n;
    int    p;
    n = (len == 0) ? 1 : ((len > PATTERN_MAX) ? PATTERN_MAX : int'(len));
    p = int'(start);
    for (int j = 0; j < BYTE_W; j++) begin
      w.pbyte[BYTE_W-1-j] = bits[p];
      p = (p + 1 >= n) ? 0 : p + 1;
    end
    w.next_pos = p[POS_W-1:0];
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: results are scored before the same edge's input is predicted
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t got;
    result_t want;
    walk_t   w;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = '{offset: m_tdata[41:10], first: m_tdata[9], mis: m_tdata[8],
                pbyte: m_tdata[7:0], done: m_tlast};
        if (pending_results.size() == 0) begin
          $error("result item with nothing pending: m_tdata=%h m_tlast=%b", m_tdata, m_tlast);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.pbyte !== want.pbyte) begin
            $error("pattern_byte: expected %h, got %h", want.pbyte, got.pbyte);
            errors++;
          end
          if (got.mis !== want.mis) begin
            $error("mismatch: expected %b, got %b", want.mis, got.mis);
            errors++;
          end
          if (got.first !== want.first) begin
            $error("first_mismatch: expected %b, got %b", want.first, got.first);
            errors++;
          end
          if (got.offset !== want.offset) begin
            $error("byte_offset: expected %0d, got %0d", want.offset, got.offset);
            errors++;
          end
          if (got.done !== want.done) begin
            $error("range_done: expected %b, got %b", want.done, got.done);
            errors++;
          end
          if (m_tdata[47:42] !== 6'b0) begin
            $error("tdata pad: expected %h, got %h", 6'b0, m_tdata[47:42]);
            errors++;
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        n_cfg++;
        if (cfg_index == REG_PATTERN_BITS) pat_bits = cfg_data;
        else pat_len = cfg_data[LEN_W-1:0];
      end

      if (s_tvalid && s_tready) begin
        w = walk_pattern(pat_bits, pat_len, bit_pos);
        want.pbyte  = w.pbyte;
        want.mis    = (s_tuser == CMD_CHECK) && (s_tdata != w.pbyte);
        want.first  = want.mis && !range_failed;
        want.offset = offset_cnt;
        want.done   = s_tlast;
        if (want.mis) range_failed = 1'b1;
        // range end restarts position, offset and the failed flag
        if (s_tlast) begin
          bit_pos      = '0;
          offset_cnt   = '0;
          range_failed = 1'b0;
          n_ranges++;
        end else begin
          bit_pos    = w.next_pos;
          offset_cnt = offset_cnt + 1;
        end
        n_items++;
        if (s_tuser == CMD_CHECK) n_checks++;
        if (want.mis) n_mis++;
        if (want.first) n_first++;
        pending_results.push_back(row_known ? row_res : want);
      end
    end
  end

  // watchdog: any handshake resets the count
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: %0d cycles without a handshake", IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // receiver: drops m_tready in random stall bursts, none while calm
  always @(negedge clk) begin
    if (calm) begin
      stall_left = 0;
      m_tready = 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      m_tready = 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 6);
      m_tready = 1'b0;
    end else
      m_tready = 1'b1;
  end

  // --------------------------------------------------------------------------
  // Sender tasks; each starts and ends just after a falling edge
  // --------------------------------------------------------------------------
  task automatic push_item(input logic cmd, input logic [BYTE_W-1:0] data, input logic last);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = cmd;
    s_tdata  = data;
    s_tlast  = last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold the sender until every owed result is back
  task automatic drain();
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // registers change only with the block idle
  task automatic write_reg(input logic idx, input logic [PATTERN_MAX-1:0] val);
    drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic plan_cfg(input logic idx, input logic [PATTERN_MAX-1:0] val);
    plan_row_t r;
    r = '0;
    r.is_cfg  = 1'b1;
    r.cfg_idx = idx;
    r.cfg_val = val;
    plan.push_back(r);
  endtask

  task automatic plan_item(input logic cmd, input logic [BYTE_W-1:0] data, input logic last);
    plan_row_t r;
    r = '0;
    r.cmd  = cmd;
    r.data = data;
    r.last = last;
    plan.push_back(r);
  endtask

  task automatic plan_known(input logic cmd, input logic [BYTE_W-1:0] data, input logic last,
                            input logic [BYTE_W-1:0] pbyte, input logic mis,
                            input logic first, input logic [OFFSET_W-1:0] offset);
    plan_row_t r;
    r.is_cfg  = 1'b0;
    r.cfg_idx = REG_PATTERN_BITS;
    r.cfg_val = '0;
    r.cmd     = cmd;
    r.data    = data;
    r.last    = last;
    r.known   = 1'b1;
    r.res     = '{offset: offset, first: first, mis: mis, pbyte: pbyte, done: last};
    plan.push_back(r);
  endtask

  // random item: mostly a check with the right byte, some flipped bits, some noise
  task automatic random_item(input logic last);
    walk_t             w;
    logic [BYTE_W-1:0] d;
    logic              c;
    w = walk_pattern(pat_bits, pat_len, bit_pos);
    c = ($urandom_range(0, 9) < 7) ? CMD_CHECK : CMD_FILL;
    case ($urandom_range(0, 19))
      0, 1, 2, 3: d = w.pbyte ^ (8'h01 << $urandom_range(0, 7));
      4:          d = ~w.pbyte;
      5, 6:       d = 8'($urandom);
      default:    d = w.pbyte;
    endcase
    row_known = 1'b0;
    push_item(c, d, last);
  endtask

  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(0, 9))
      0:       return LEN_W'(1);
      1:       return LEN_W'(PATTERN_MAX);
      2:       return '0;                               // acts as one
      3:       return LEN_W'($urandom_range(65, 127));  // acts as PATTERN_MAX
      4:       return LEN_W'(BYTE_W);
      default: return LEN_W'($urandom_range(2, 63));
    endcase
  endfunction

  function automatic logic [PATTERN_MAX-1:0] pick_bits();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    plan_row_t              r;
    logic [PATTERN_MAX-1:0] len_word;
    int                     phase_items;
    logic                   last;

    // reset pattern is all zero, length 8
    plan_known(CMD_FILL,  8'h5A, 1'b0, 8'h00, 1'b0, 1'b0, 0);
    plan_known(CMD_CHECK, 8'hFF, 1'b0, 8'h00, 1'b1, 1'b1, 1);
    plan_known(CMD_CHECK, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 2);
    plan_known(CMD_CHECK, 8'h80, 1'b0, 8'h00, 1'b1, 1'b0, 3);  // later mismatch
    plan_known(CMD_FILL,  8'hA5, 1'b1, 8'h00, 1'b0, 1'b0, 4);  // data ignored
    // all ones, full length
    plan_cfg(REG_PATTERN_BITS, '1);
    plan_cfg(REG_PATTERN_LEN, 64'd64);
    plan_known(CMD_FILL,  8'h00, 1'b0, 8'hFF, 1'b0, 1'b0, 0);
    plan_known(CMD_CHECK, 8'hFF, 1'b1, 8'hFF, 1'b0, 1'b0, 1);
    // length zero acts as one: bit 0 repeats
    plan_cfg(REG_PATTERN_BITS, 64'h1);
    plan_cfg(REG_PATTERN_LEN, 64'd0);
    plan_known(CMD_CHECK, 8'h7F, 1'b0, 8'hFF, 1'b1, 1'b1, 0);
    plan_known(CMD_CHECK, 8'hFF, 1'b1, 8'hFF, 1'b0, 1'b0, 1);
    // length 127 clamps to 64; nine bytes wrap past the end of the pattern
    plan_cfg(REG_PATTERN_BITS, 64'h8000_0000_0000_0001);
    plan_cfg(REG_PATTERN_LEN, 64'd127);
    plan_item(CMD_CHECK, 8'h80, 1'b0);
    plan_item(CMD_FILL,  8'hFF, 1'b0);
    plan_item(CMD_CHECK, 8'h00, 1'b0);
    plan_item(CMD_CHECK, 8'h01, 1'b0);
    plan_item(CMD_FILL,  8'h00, 1'b0);
    plan_item(CMD_CHECK, 8'h00, 1'b0);
    plan_item(CMD_CHECK, 8'h00, 1'b0);
    plan_item(CMD_CHECK, 8'h01, 1'b0);
    plan_item(CMD_CHECK, 8'h80, 1'b1);
    // odd length crossing byte boundaries, then shrink under a stale position
    plan_cfg(REG_PATTERN_BITS, 64'h0000_0000_0000_1B5A);
    plan_cfg(REG_PATTERN_LEN, 64'd13);
    plan_item(CMD_FILL,  8'h00, 1'b0);
    plan_cfg(REG_PATTERN_LEN, 64'd3);
    plan_item(CMD_CHECK, 8'h00, 1'b0);
    plan_item(CMD_CHECK, 8'hFF, 1'b1);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      r = plan[i];
      if (r.is_cfg)
        write_reg(r.cfg_idx, r.cfg_val);
      else begin
        row_known = r.known;
        row_res   = r.res;
        push_item(r.cmd, r.data, r.last);
      end
    end
    row_known = 1'b0;

    // random phases: new register settings between bursts of items; ranges
    // may run on across a register change
    while (n_random < RAND_ITEMS) begin
      calm = (n_random >= RAND_ITEMS * 3 / 4) || ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 2) != 0) write_reg(REG_PATTERN_BITS, pick_bits());
      if ($urandom_range(0, 2) != 0) begin
        // upper bits of the data word carry noise the length register drops
        len_word = {$urandom, $urandom};
        len_word[LEN_W-1:0] = pick_len();
        write_reg(REG_PATTERN_LEN, len_word);
      end
      phase_items = $urandom_range(18, 36);
      for (int k = 0; k < phase_items; k++) begin
        if (range_left == 0)
          range_left = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 40)
                                                   : $urandom_range(1, 8);
        last = (range_left == 1);
        range_left--;
        random_item(last);
        n_random++;
      end
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d result items never arrived", pending_results.size());
      errors++;
    end

    $display("Covered %0d items: %0d checks, %0d mismatches, %0d first of range.",
             n_items, n_checks, n_mis, n_first);
    $display("Closed %0d ranges over %0d register writes.", n_ranges, n_cfg);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/rbpfc_pkg.sv
rtl/core/rbpfc_bitgen.sv
rtl/core/rbpfc_shift.sv
rtl/core/repeating_bit_pattern_fill_check.sv
test/repeating_bit_pattern_fill_check_tb.sv
